// ===== design/crt_pkg.sv =====
// crt_pkg: shared constants and types of the chunk reassembly tracker
// field widths, register indexes and status codes
// no dependencies
package crt_pkg;

  // sizing
  localparam int DEF_MAX_CHUNKS = 1024;
  localparam int CHUNK_SHIFT    = 16;
  localparam int CHUNK_SIZE     = 1 << CHUNK_SHIFT;
  localparam int TOTAL_W        = 27;
  localparam int COUNT_W        = TOTAL_W + 1 - CHUNK_SHIFT;
  localparam int OFF_W          = COUNT_W + CHUNK_SHIFT;
  localparam int OFFSET_OUT_W   = 26;
  localparam int RCOUNT_OUT_W   = 11;

  // stream and register port widths
  localparam int IN_W    = 432;
  localparam int OUT_W   = 48;
  localparam int OUT_PAD = OUT_W - (4 + OFFSET_OUT_W + RCOUNT_OUT_W + 1);
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;

  // register indexes
  localparam logic [2:0] REG_OBJECT_TYPE = 3'd0;
  localparam logic [2:0] REG_HASH_WORD0  = 3'd1;
  localparam logic [2:0] REG_HASH_WORD1  = 3'd2;
  localparam logic [2:0] REG_HASH_WORD2  = 3'd3;
  localparam logic [2:0] REG_HASH_WORD3  = 3'd4;
  localparam logic [2:0] REG_OBJECT_LEN  = 3'd5;

  // result codes
  typedef enum logic [3:0] {
    ST_STORED      = 4'd0,
    ST_DUPLICATE   = 4'd1,
    ST_ZERO_TOTAL  = 4'd2,
    ST_PAST_END    = 4'd3,
    ST_EMPTY       = 4'd4,
    ST_OVERSIZE    = 4'd5,
    ST_SHORT       = 4'd6,
    ST_TYPE        = 4'd7,
    ST_HASH        = 4'd8,
    ST_COUNT       = 4'd9,
    ST_INDEX_RANGE = 4'd10,
    ST_LENGTH      = 4'd11
  } status_t;

endpackage

// ===== design/crt_ram.sv =====
// crt_ram: generic single-clock ram, one write and one read port
// read data is registered and holds while no read is issued
// no dependencies
module crt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/chunk_reassembly_tracker_unit.sv =====
// chunk_reassembly_tracker_unit: header checks and received bitmap for one chunked object
// depends on crt_pkg and crt_ram
//
//  channel   signals                              moves
//  cfg       psel penable pwrite paddr pwdata     register writes and reads
//  s_axis    tvalid tready tdata                  one chunk header per item
//  m_axis    tvalid tready tdata                  one status result per item
//
// an item has header checks and the bitmap read in the accept cycle, then
// the bitmap lookup, write-back and count update in S_LOOKUP
// after reset the bitmap ram is cleared one entry a cycle over all MAX_CHUNKS
// entries, and s_axis_tready stays low meanwhile; config writes are taken throughout
// a held result does not block the next accept; the lookup waits for the
// output register to free up, and the next read follows the write-back
module chunk_reassembly_tracker_unit #(
  parameter int MAX_CHUNKS = crt_pkg::DEF_MAX_CHUNKS
) (
  input  logic                       clk,
  input  logic                       rst,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crt_pkg::ADDR_W-1:0] paddr,
  input  logic [crt_pkg::DATA_W-1:0] pwdata,
  output logic [crt_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // chunk header in
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // chunk_type 16, chunk_hash0..3 64 each, chunk_idx 64, chunk_total 64,
  // payload_len 32 (lowest bits first)
  input  logic [crt_pkg::IN_W-1:0]   s_axis_tdata,
  // result out
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // status 4, write_offset 26, received_count 11, complete 1, zero pad
  output logic [crt_pkg::OUT_W-1:0]  m_axis_tdata
);

  import crt_pkg::*;

  localparam int AW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_t;

  // configuration registers
  logic [15:0]        object_type;
  logic [63:0]        hash_word0;
  logic [63:0]        hash_word1;
  logic [63:0]        hash_word2;
  logic [63:0]        hash_word3;
  logic [TOTAL_W-1:0] object_len;

  // control and held item
  state_t                  state;
  logic [AW-1:0]           clr_addr;
  logic [CNT_W-1:0]        received_total;
  status_t                 pre_status;
  logic [AW-1:0]           idx_addr;
  logic [OFFSET_OUT_W-1:0] idx_offset;

  // output register
  status_t                 out_status;
  logic [OFFSET_OUT_W-1:0] out_offset;
  logic [RCOUNT_OUT_W-1:0] out_count;
  logic                    out_complete;

  // input fields
  logic [15:0] chunk_type;
  logic [63:0] chunk_hash0;
  logic [63:0] chunk_hash1;
  logic [63:0] chunk_hash2;
  logic [63:0] chunk_hash3;
  logic [63:0] chunk_idx;
  logic [63:0] chunk_total;
  logic [31:0] payload_len;

  assign chunk_type  = s_axis_tdata[15:0];
  assign chunk_hash0 = s_axis_tdata[79:16];
  assign chunk_hash1 = s_axis_tdata[143:80];
  assign chunk_hash2 = s_axis_tdata[207:144];
  assign chunk_hash3 = s_axis_tdata[271:208];
  assign chunk_idx   = s_axis_tdata[335:272];
  assign chunk_total = s_axis_tdata[399:336];
  assign payload_len = s_axis_tdata[431:400];

  // register port
  logic       cfg_we;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      REG_OBJECT_TYPE: prdata = DATA_W'(object_type);
      REG_HASH_WORD0:  prdata = hash_word0;
      REG_HASH_WORD1:  prdata = hash_word1;
      REG_HASH_WORD2:  prdata = hash_word2;
      REG_HASH_WORD3:  prdata = hash_word3;
      REG_OBJECT_LEN:  prdata = DATA_W'(object_len);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      object_type <= '0;
      hash_word0  <= '0;
      hash_word1  <= '0;
      hash_word2  <= '0;
      hash_word3  <= '0;
      object_len  <= '0;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_OBJECT_TYPE: object_type <= pwdata[15:0];
        REG_HASH_WORD0:  hash_word0  <= pwdata;
        REG_HASH_WORD1:  hash_word1  <= pwdata;
        REG_HASH_WORD2:  hash_word2  <= pwdata;
        REG_HASH_WORD3:  hash_word3  <= pwdata;
        REG_OBJECT_LEN:  object_len  <= pwdata[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // expected chunk count, total length rounded up to whole chunks
  logic [TOTAL_W:0]   round_sum;
  logic [COUNT_W-1:0] exp_count;

  assign round_sum = {1'b0, object_len} + (TOTAL_W + 1)'(CHUNK_SIZE - 1);
  assign exp_count = round_sum[TOTAL_W:CHUNK_SHIFT];

  // byte offset of the chunk and its expected length, full size unless it is the last
  logic [OFF_W-1:0] chunk_off;
  logic [OFF_W-1:0] remain;
  logic [OFF_W-1:0] want_len;

  assign chunk_off = {chunk_idx[COUNT_W-1:0], {CHUNK_SHIFT{1'b0}}};
  assign remain    = OFF_W'(object_len) - chunk_off;
  assign want_len  = (remain > OFF_W'(CHUNK_SIZE)) ? OFF_W'(CHUNK_SIZE) : remain;

  // header checks in priority order; stored here means all checks passed
  status_t chk_status;

  always_comb begin
    if (chunk_total == 64'd0) begin
      chk_status = ST_ZERO_TOTAL;
    end else if (chunk_idx >= chunk_total) begin
      chk_status = ST_PAST_END;
    end else if (payload_len == 32'd0) begin
      chk_status = ST_EMPTY;
    end else if (payload_len > 32'(CHUNK_SIZE)) begin
      chk_status = ST_OVERSIZE;
    end else if ((chunk_idx != chunk_total - 64'd1) &&
                 (payload_len != 32'(CHUNK_SIZE))) begin
      chk_status = ST_SHORT;
    end else if (chunk_type != object_type) begin
      chk_status = ST_TYPE;
    end else if ((chunk_hash0 != hash_word0) || (chunk_hash1 != hash_word1) ||
                 (chunk_hash2 != hash_word2) || (chunk_hash3 != hash_word3)) begin
      chk_status = ST_HASH;
    end else if (chunk_total != 64'(exp_count)) begin
      chk_status = ST_COUNT;
    end else if ((chunk_idx >= 64'(exp_count)) ||
                 (chunk_idx >= 64'(MAX_CHUNKS))) begin
      chk_status = ST_INDEX_RANGE;
    end else if (payload_len != 32'(want_len)) begin
      chk_status = ST_LENGTH;
    end else begin
      chk_status = ST_STORED;
    end
  end

  // bitmap ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_re;
  logic          ram_rdata;

  crt_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CHUNKS),
    .AW    (AW)
  ) u_seen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (chunk_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // handshake and lookup control
  logic             in_acc;
  logic             out_free;
  logic             lookup_go;
  logic             store_new;
  logic [CNT_W-1:0] count_next;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign lookup_go     = (state == S_LOOKUP) && out_free;
  assign store_new     = lookup_go && (pre_status == ST_STORED) && !ram_rdata;
  assign count_next    = store_new ? received_total + CNT_W'(1) : received_total;
  assign ram_re        = in_acc;

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = store_new;
      ram_waddr = idx_addr;
      ram_wdata = 1'b1;
    end
  end

  // state, held item and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      received_total <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      // result valid: raised by a lookup, dropped once taken
      if (lookup_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAX_CHUNKS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            pre_status <= chk_status;
            idx_addr   <= chunk_idx[AW-1:0];
            idx_offset <= chunk_off[OFFSET_OUT_W-1:0];
            state      <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (lookup_go) begin
            received_total <= count_next;
            out_count      <= RCOUNT_OUT_W'(count_next);
            out_complete   <= (32'(count_next) == 32'(exp_count));
            if (pre_status == ST_STORED && ram_rdata) begin
              out_status <= ST_DUPLICATE;
              out_offset <= '0;
            end else if (pre_status == ST_STORED) begin
              out_status <= ST_STORED;
              out_offset <= idx_offset;
            end else begin
              out_status <= pre_status;
              out_offset <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign m_axis_tdata = {{OUT_PAD{1'b0}}, out_complete, out_count, out_offset, out_status};

endmodule
